// File: rtl/core/wsf_pkg.sv
// wsf_pkg: shared constants, types and character helpers for the substring finder
// used by the channel interfaces and every module under rtl/core
// no dependencies
package wsf_pkg;

  localparam int MAX_NEEDLE    = 64;
  localparam int CHAR_BITS     = 16;
  localparam int WIN_DEPTH     = MAX_NEEDLE + 1;
  localparam int SLOT_BITS     = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int LEN_BITS      = 7;
  localparam int POS_BITS      = 31;
  localparam int OPC_BITS      = 2;
  localparam int IN_CHAR_BITS  = 16;
  localparam int IN_IDX_BITS   = 6;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 31;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POS_BITS-1:0]  POS_MAX       = '1;
  localparam logic [CHAR_BITS-1:0] CH_UNDERSCORE = CHAR_BITS'(8'h5F);
  localparam logic [CHAR_BITS-1:0] CH_DIGIT_0    = CHAR_BITS'(8'h30);
  localparam logic [CHAR_BITS-1:0] CH_DIGIT_9    = CHAR_BITS'(8'h39);
  localparam logic [CHAR_BITS-1:0] CH_UPPER_A    = CHAR_BITS'(8'h41);
  localparam logic [CHAR_BITS-1:0] CH_UPPER_Z    = CHAR_BITS'(8'h5A);
  localparam logic [CHAR_BITS-1:0] CH_LOWER_A    = CHAR_BITS'(8'h61);
  localparam logic [CHAR_BITS-1:0] CH_LOWER_Z    = CHAR_BITS'(8'h7A);

  typedef enum logic [OPC_BITS-1:0] {
    OP_LOAD = 2'd0,
    OP_TEXT = 2'd1,
    OP_END  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NEEDLE_LENGTH  = 2'd0,
    REG_CASE_SENSITIVE = 2'd1,
    REG_WHOLE_WORDS    = 2'd2,
    REG_START_OFFSET   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t                  op;
    logic [CHAR_BITS-1:0] ch;
    logic [SLOT_BITS-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] needle_length;
    logic                case_sensitive;
    logic                whole_words;
    logic [POS_BITS-1:0] start_offset;
  } cfg_t;

  function automatic logic is_word_char(input logic [CHAR_BITS-1:0] c);
    logic w;
    w = (c == CH_UNDERSCORE) ||
        (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
        (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
        (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    return w;
  endfunction

  function automatic logic [CHAR_BITS-1:0] fold_char(input logic [CHAR_BITS-1:0] c,
                                                     input logic exact);
    logic [CHAR_BITS-1:0] r;
    r = c;
    if (!exact && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      r = c - CH_LOWER_A + CH_UPPER_A;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/wsf_ifs.sv
// wsf_ifs: valid/ready channel interfaces for input words, result words and register writes
// depends on wsf_pkg for field widths
interface wsf_item_if;
  import wsf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OPC_BITS-1:0]     opcode;
  logic [IN_CHAR_BITS-1:0] char_value;
  logic [IN_IDX_BITS-1:0]  needle_index;
  modport source (output valid, opcode, char_value, needle_index, input ready);
  modport sink (input valid, opcode, char_value, needle_index, output ready);
endinterface

interface wsf_result_if;
  import wsf_pkg::*;
  logic                valid;
  logic                ready;
  logic                found;
  logic [POS_BITS-1:0] match_position;
  modport source (output valid, found, match_position, input ready);
  modport sink (input valid, found, match_position, output ready);
endinterface

interface wsf_cfg_if;
  import wsf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/wsf_front.sv
// wsf_front: accepts input words, decodes the opcode and drops words with no effect
// depends on wsf_pkg and wsf_item_if
module wsf_front (
  wsf_item_if.sink       item,
  output logic           push_valid,
  output wsf_pkg::cmd_t  push_cmd,
  input  logic           push_ready
);
  import wsf_pkg::*;

  logic keep;

  always_comb begin
    push_cmd.op   = op_t'(item.opcode);
    push_cmd.ch   = CHAR_BITS'(item.char_value);
    push_cmd.slot = SLOT_BITS'(item.needle_index);
    unique case (item.opcode)
      OP_LOAD: keep = (int'(item.needle_index) < MAX_NEEDLE);
      OP_TEXT: keep = 1'b1;
      OP_END:  keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  // unused opcodes and out of range slots are consumed here and never queued
  assign item.ready = push_ready;
  assign push_valid = item.valid && keep;

endmodule

// File: rtl/core/wsf_queue.sv
// wsf_queue: short flop fifo of decoded commands between front and back
// depends on wsf_pkg
module wsf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  wsf_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output wsf_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);
  import wsf_pkg::*;

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/wsf_back.sv
// wsf_back: needle store, text window shift line, parallel comparators, match tracking
// and the result register; depends on wsf_pkg and wsf_result_if
module wsf_back (
  input  logic          clk,
  input  logic          rst,
  input  wsf_pkg::cfg_t cfg,
  input  logic          pop_valid,
  input  wsf_pkg::cmd_t pop_cmd,
  output logic          pop_ready,
  wsf_result_if.source  result
);
  import wsf_pkg::*;

  logic [CHAR_BITS-1:0] needle   [MAX_NEEDLE];
  logic [CHAR_BITS-1:0] window   [WIN_DEPTH];
  logic [CHAR_BITS-1:0] win_next [WIN_DEPTH];
  logic [CHAR_BITS-1:0] bar      [SLOT_BITS+1][MAX_NEEDLE];

  logic [POS_BITS-1:0]   text_pos;
  logic                  done;
  logic                  pending;
  logic [POS_BITS-1:0]   pend_pos;
  logic                  res_valid;
  logic                  res_found;
  logic [POS_BITS-1:0]   res_pos;

  logic                  take;
  logic                  take_end;
  logic                  c_word;
  logic [SLOT_BITS-1:0]  shamt;
  logic [MAX_NEEDLE-1:0] match_vec;
  logic                  left_word;
  logic                  len_ok;
  logic [POS_BITS:0]     p1;
  logic [POS_BITS:0]     cand_full;
  logic [POS_BITS-1:0]   cand_pos;
  logic                  reach;
  logic                  start_ok;
  logic                  at_max;
  logic                  hit;

  assign pop_ready = (pop_cmd.op != OP_END) || !res_valid || result.ready;
  assign take      = pop_valid && pop_ready;
  assign take_end  = take && (pop_cmd.op == OP_END);
  assign c_word    = is_word_char(pop_cmd.ch);

  // window as it stands once this character has shifted in
  always_comb begin
    win_next[0] = pop_cmd.ch;
    for (int s = 1; s < WIN_DEPTH; s++) begin
      win_next[s] = window[s-1];
    end
  end

  // reverse the window and shift it down so that lane k lines up with needle slot k
  assign shamt = SLOT_BITS'(MAX_NEEDLE - int'(cfg.needle_length));

  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      bar[0][i] = win_next[MAX_NEEDLE-1-i];
    end
    for (int b = 0; b < SLOT_BITS; b++) begin
      for (int k = 0; k < MAX_NEEDLE; k++) begin
        if (shamt[b]) begin
          if (k + (1 << b) < MAX_NEEDLE) begin
            bar[b+1][k] = bar[b][k + (1 << b)];
          end else begin
            bar[b+1][k] = '0;
          end
        end else begin
          bar[b+1][k] = bar[b][k];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      match_vec[k] = (k >= int'(cfg.needle_length)) ||
                     (fold_char(bar[SLOT_BITS][k], cfg.case_sensitive) ==
                      fold_char(needle[k], cfg.case_sensitive));
    end
  end

  // character just before the candidate; at position zero this slot is still cleared
  always_comb begin
    left_word = 1'b0;
    for (int s = 0; s < WIN_DEPTH; s++) begin
      if (s == int'(cfg.needle_length)) begin
        left_word = is_word_char(win_next[s]);
      end
    end
  end

  assign len_ok    = (cfg.needle_length != '0) && (int'(cfg.needle_length) <= MAX_NEEDLE);
  assign p1        = {1'b0, text_pos} + (POS_BITS+1)'(1);
  assign reach     = p1 >= (POS_BITS+1)'(cfg.needle_length);
  assign cand_full = p1 - (POS_BITS+1)'(cfg.needle_length);
  assign cand_pos  = cand_full[POS_BITS-1:0];
  assign start_ok  = cand_pos >= cfg.start_offset;
  assign at_max    = (text_pos == POS_MAX);
  assign hit       = len_ok && reach && start_ok && !at_max && (&match_vec);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < WIN_DEPTH; s++) begin
        window[s] <= '0;
      end
      text_pos  <= '0;
      done      <= 1'b0;
      pending   <= 1'b0;
      pend_pos  <= '0;
      res_valid <= 1'b0;
    end else begin
      if (take_end) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      if (take) begin
        unique case (pop_cmd.op)
          OP_TEXT: begin
            if (!done) begin
              if (pending && !c_word) begin
                // right side of the held candidate is a non-word character
                pending <= 1'b0;
                done    <= 1'b1;
              end else begin
                window  <= win_next;
                if (!at_max) begin
                  text_pos <= text_pos + POS_BITS'(1);
                end
                pending <= hit && cfg.whole_words && !left_word;
                if (hit && !cfg.whole_words) begin
                  done <= 1'b1;
                end
                if (hit && (!cfg.whole_words || !left_word)) begin
                  pend_pos <= cand_pos;
                end
              end
            end
          end
          OP_END: begin
            for (int s = 0; s < WIN_DEPTH; s++) begin
              window[s] <= '0;
            end
            text_pos <= '0;
            done     <= 1'b0;
            pending  <= 1'b0;
            pend_pos <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && pop_cmd.op == OP_LOAD) begin
      needle[pop_cmd.slot] <= pop_cmd.ch;
    end
    if (take_end) begin
      res_found <= done || pending;
      res_pos   <= (done || pending) ? pend_pos : '0;
    end
  end

  assign result.valid          = res_valid;
  assign result.found          = res_found;
  assign result.match_position = res_pos;

`ifndef SYNTH
  a_pend_done_excl: assert property (@(posedge clk) disable iff (rst)
    !(pending && done))
    else $error("held candidate coexists with a confirmed match");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_found) |-> (res_pos == '0))
    else $error("not-found result carries a nonzero position");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    take_end |=> (text_pos == '0 && !done && !pending))
    else $error("search state not cleared after end of text");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (take && pop_cmd.op != OP_END) |=>
      (text_pos == $past(text_pos) || text_pos == $past(text_pos) + POS_BITS'(1)))
    else $error("text position moved by more than one");
`endif

endmodule

// File: rtl/core/wide_substring_find.sv
// wide_substring_find: top level with the register file, front decoder, command queue
// and match engine; depends on wsf_pkg, wsf_ifs, wsf_front, wsf_queue and wsf_back
//
// Streams 16-bit code units and reports the first position at or after start_offset
// where the loaded needle occurs, optionally folding ASCII case and requiring word
// boundaries. Input words (needle load, text character, end of text) are taken one per
// cycle unless stalled: each text character is compared against all needle slots in
// the cycle it leaves the four-entry command queue, using 64 parallel comparators on
// a 65-deep shift-register window. Only end of text produces a result word; it sits
// in an output register from the cycle after the end word leaves the queue, and the
// next end word waits in the queue while that result is still untaken. No clearing
// pass follows reset. Registers are taken at any cycle, but write them only while no
// word is in flight: a new value applies to every word the engine takes afterwards,
// words still waiting in the queue included.
module wide_substring_find (
  input  logic         clk,
  input  logic         rst,
  wsf_item_if.sink     item,
  wsf_cfg_if.sink      cfg,
  wsf_result_if.source result
);
  import wsf_pkg::*;

  cfg_t cfg_regs;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.needle_length  <= '0;
      cfg_regs.case_sensitive <= 1'b1;
      cfg_regs.whole_words    <= 1'b0;
      cfg_regs.start_offset   <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_NEEDLE_LENGTH:  cfg_regs.needle_length  <= cfg.data[LEN_BITS-1:0];
        REG_CASE_SENSITIVE: cfg_regs.case_sensitive <= cfg.data[0];
        REG_WHOLE_WORDS:    cfg_regs.whole_words    <= cfg.data[0];
        REG_START_OFFSET:   cfg_regs.start_offset   <= cfg.data[POS_BITS-1:0];
      endcase
    end
  end

  wsf_front u_front (
    .item       (item),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  wsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  wsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .result    (result)
  );

endmodule

// File: bench/tb.sv
// tb: self-checking bench for wide_substring_find, with a directed script and then random searches
// depends on wsf_pkg, the wsf_ifs channel interfaces and the rtl under rtl/core
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsf_pkg::*;

  localparam logic [OPC_BITS-1:0] OP_ILLEGAL = 2'd3;

  typedef struct packed {
    logic                found;
    logic [POS_BITS-1:0] pos;
  } search_hit_t;

  typedef struct {
    bit                    reg_row;
    logic [OPC_BITS-1:0]   op;
    cfg_reg_t              reg_sel;
    logic [POS_BITS-1:0]   data;
    logic [CHAR_BITS-1:0]  ch;
    logic [SLOT_BITS-1:0]  idx;
    bit                    typed;
    search_hit_t           want;
  } script_row_t;

  logic clk;
  logic rst;

  wsf_item_if   item_ch();
  wsf_cfg_if    cfg_ch();
  wsf_result_if res_ch();

  wide_substring_find dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch.sink),
    .cfg   (cfg_ch.sink),
    .result(res_ch.source)
  );

  // search model state
  logic [CHAR_BITS-1:0] needle_mem [MAX_NEEDLE];
  logic [CHAR_BITS-1:0] text_win [WIN_DEPTH];
  logic [POS_BITS-1:0]  text_pos;
  bit                   hit_done;
  bit                   await_right;
  logic [POS_BITS-1:0]  hit_pos;
  logic [LEN_BITS-1:0]  cur_len;
  bit                   cur_exact;
  bit                   cur_whole;
  logic [POS_BITS-1:0]  cur_offset;

  bit                   slot_written [MAX_NEEDLE];
  search_hit_t          expected_hits [$];
  script_row_t          script [$];

  int burst_left;
  int words_sent;
  int results_seen;
  int hits_seen;
  int reg_writes;
  int err_count;
  int ready_mode;
  int ready_left;
  int ready_tick;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic bit word_char(input logic [CHAR_BITS-1:0] c);
    return c == CH_UNDERSCORE ||
           (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) ||
           (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic logic [CHAR_BITS-1:0] upcase(input logic [CHAR_BITS-1:0] c);
    if (!cur_exact && c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      return c - CH_LOWER_A + CH_UPPER_A;
    end
    return c;
  endfunction

  function automatic void clear_search();
    foreach (text_win[i]) text_win[i] = '0;
    text_pos = '0;
    hit_done = 1'b0;
    await_right = 1'b0;
    hit_pos = '0;
  endfunction

  function automatic void shift_text(input logic [CHAR_BITS-1:0] c);
    logic [POS_BITS-1:0] p;
    logic [POS_BITS-1:0] start;
    int unsigned len;
    bit ok;
    if (hit_done) return;
    // a pending whole-word match is settled by this character first
    if (await_right) begin
      await_right = 1'b0;
      if (!word_char(c)) begin
        hit_done = 1'b1;
        return;
      end
    end
    for (int i = WIN_DEPTH - 1; i > 0; i--) text_win[i] = text_win[i-1];
    text_win[0] = c;
    if (text_pos == POS_MAX) return;
    p = text_pos;
    text_pos = p + 1'b1;
    len = cur_len;
    if (len == 0 || len > MAX_NEEDLE || longint'(p) + 1 < longint'(len)) return;
    start = POS_BITS'(longint'(p) + 1 - longint'(len));
    if (start < cur_offset) return;
    ok = 1'b1;
    for (int k = 0; k < len; k++) begin
      if (upcase(text_win[len-1-k]) != upcase(needle_mem[k])) ok = 1'b0;
    end
    if (!ok) return;
    if (cur_whole) begin
      if (start != 0 && word_char(text_win[len])) return;
      await_right = 1'b1;
      hit_pos = start;
      return;
    end
    hit_done = 1'b1;
    hit_pos = start;
  endfunction

  function automatic void model_word(input logic [OPC_BITS-1:0] op,
                                     input logic [CHAR_BITS-1:0] ch,
                                     input logic [SLOT_BITS-1:0] idx,
                                     output bit emit, output search_hit_t res);
    emit = 1'b0;
    res = '0;
    case (op)
      OP_LOAD: needle_mem[idx] = ch;
      OP_TEXT: shift_text(ch);
      OP_END: begin
        if (!hit_done && await_right) hit_done = 1'b1;
        emit = 1'b1;
        res.found = hit_done;
        res.pos = hit_done ? hit_pos : '0;
        clear_search();
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [OPC_BITS-1:0] op, input logic [CHAR_BITS-1:0] ch,
                           input logic [SLOT_BITS-1:0] idx, input bit typed = 1'b0,
                           input search_hit_t want = '0);
    bit emit;
    search_hit_t res;
    if (burst_left == 0) begin
      // some bursts follow straight on, the rest after a gap
      if ($urandom_range(0, 4) != 0) begin
        item_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    item_ch.valid        <= 1'b1;
    item_ch.opcode       <= op;
    item_ch.char_value   <= ch;
    item_ch.needle_index <= idx;
    do @(posedge clk); while (!item_ch.ready);
    model_word(op, ch, idx, emit, res);
    if (op == OP_LOAD) slot_written[idx] = 1'b1;
    if (op != OP_ILLEGAL) words_sent++;
    if (emit) expected_hits.push_back(typed ? want : res);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [POS_BITS-1:0] d);
    item_ch.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    // let words still in the command queue drain
    repeat (16) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (sel)
      REG_NEEDLE_LENGTH:  cur_len = d[LEN_BITS-1:0];
      REG_CASE_SENSITIVE: cur_exact = d[0];
      REG_WHOLE_WORDS:    cur_whole = d[0];
      REG_START_OFFSET:   cur_offset = d;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic add_word(input logic [OPC_BITS-1:0] op, input logic [CHAR_BITS-1:0] ch,
                          input logic [SLOT_BITS-1:0] idx);
    script_row_t r;
    r = '{reg_sel: REG_NEEDLE_LENGTH, default: '0};
    r.op = op;
    r.ch = ch;
    r.idx = idx;
    script.push_back(r);
  endtask

  task automatic add_reg(input cfg_reg_t sel, input logic [POS_BITS-1:0] d);
    script_row_t r;
    r = '{reg_sel: REG_NEEDLE_LENGTH, default: '0};
    r.reg_row = 1'b1;
    r.reg_sel = sel;
    r.data = d;
    script.push_back(r);
  endtask

  task automatic add_end(input bit typed, input logic found, input logic [POS_BITS-1:0] pos);
    script_row_t r;
    r = '{reg_sel: REG_NEEDLE_LENGTH, default: '0};
    r.op = OP_END;
    r.typed = typed;
    r.want.found = found;
    r.want.pos = pos;
    script.push_back(r);
  endtask

  function automatic logic [CHAR_BITS-1:0] swap_case(input logic [CHAR_BITS-1:0] c);
    if ((c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z)) begin
      return c ^ 16'h0020;
    end
    return c;
  endfunction

  function automatic logic [CHAR_BITS-1:0] needle_pick();
    case ($urandom_range(0, 7))
      0: return CH_LOWER_A;
      1: return CH_UPPER_A + 16'd1;
      2: return CH_LOWER_A + 16'd2;
      3: return CH_UNDERSCORE;
      4: return CH_DIGIT_0 + 16'd1;
      5: return 16'h0020;
      6: return 16'h00E9;
      default: return CHAR_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CHAR_BITS-1:0] text_pick(input int n);
    case ($urandom_range(0, 11))
      0, 1, 2: return (n > 0) ? needle_mem[$urandom_range(0, n - 1)] : CH_LOWER_A;
      3: return (n > 0) ? swap_case(needle_mem[$urandom_range(0, n - 1)]) : CH_UPPER_A;
      4: return 16'h0020;
      5: return CH_UNDERSCORE;
      6: return CH_DIGIT_0 + CHAR_BITS'($urandom_range(0, 9));
      7: return CH_LOWER_A + CHAR_BITS'($urandom_range(0, 25));
      8: return CH_UPPER_A + CHAR_BITS'($urandom_range(0, 25));
      9: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      10: return 16'h00C0 + CHAR_BITS'($urandom_range(0, 63));
      default: return CHAR_BITS'($urandom);
    endcase
  endfunction

  task automatic run_search(input int n);
    int count;
    logic [CHAR_BITS-1:0] c;
    count = $urandom_range(0, 24);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 39))
        0: send_word(OP_ILLEGAL, CHAR_BITS'($urandom), SLOT_BITS'($urandom));
        1: send_word(OP_LOAD, needle_pick(), SLOT_BITS'($urandom_range(0, MAX_NEEDLE - 1)));
        2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          // planted copy of the needle, now and then with a letter in the other case
          for (int k = 0; k < n; k++) begin
            c = needle_mem[k];
            if ($urandom_range(0, 5) == 0) c = swap_case(c);
            send_word(OP_TEXT, c, SLOT_BITS'($urandom));
          end
          if (n == 0) send_word(OP_TEXT, text_pick(n), SLOT_BITS'($urandom));
        end
        default: send_word(OP_TEXT, text_pick(n), SLOT_BITS'($urandom));
      endcase
    end
    // an open search is sometimes carried over a register change
    if ($urandom_range(0, 9) != 0) send_word(OP_END, CHAR_BITS'($urandom), SLOT_BITS'($urandom));
  endtask

  task automatic run_phase(input bit first);
    logic [LEN_BITS-1:0] len;
    logic [POS_BITS-1:0] off;
    int n;
    bit reload;
    if (first || $urandom_range(0, 1)) begin
      case ($urandom_range(0, 19))
        0: len = '0;
        1: len = LEN_BITS'(MAX_NEEDLE);
        2: len = LEN_BITS'($urandom_range(MAX_NEEDLE + 1, 127));
        3, 4: len = LEN_BITS'($urandom_range(7, MAX_NEEDLE - 1));
        default: len = LEN_BITS'($urandom_range(1, 6));
      endcase
      write_reg(REG_NEEDLE_LENGTH, POS_BITS'(len));
    end
    if (first || $urandom_range(0, 1)) write_reg(REG_CASE_SENSITIVE, POS_BITS'($urandom_range(0, 1)));
    if (first || $urandom_range(0, 1)) write_reg(REG_WHOLE_WORDS, POS_BITS'($urandom_range(0, 1)));
    if (first || $urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 9))
        0: off = POS_MAX;
        1: off = POS_BITS'($urandom);
        2, 3, 4: off = POS_BITS'($urandom_range(1, 12));
        default: off = '0;
      endcase
      write_reg(REG_START_OFFSET, off);
    end
    n = (cur_len >= 1 && cur_len <= MAX_NEEDLE) ? int'(cur_len) : 0;
    reload = $urandom_range(0, 9) < 7;
    // every slot in use must hold a written character before text arrives
    for (int k = 0; k < n; k++) begin
      if (reload || !slot_written[k]) send_word(OP_LOAD, needle_pick(), SLOT_BITS'(k));
    end
    repeat ($urandom_range(1, 4)) run_search(n);
  endtask

  // result side: ready follows one of four patterns, picked anew at random
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(16, 80);
    end
    ready_left--;
    ready_tick++;
    case (ready_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= 1'($urandom_range(0, 1));
      2: res_ch.ready <= (ready_tick % 4 == 0);
      default: res_ch.ready <= (ready_left % 13 == 0);
    endcase
  end

  always @(posedge clk) begin
    search_hit_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_hits.size() == 0) begin
        $error("result word with no search pending: found=%0b match_position=%0d",
               res_ch.found, res_ch.match_position);
        err_count++;
      end else begin
        want = expected_hits.pop_front();
        if (res_ch.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, res_ch.found);
          err_count++;
        end
        if (res_ch.match_position !== want.pos) begin
          $error("match_position: expected %0d, got %0d", want.pos, res_ch.match_position);
          err_count++;
        end
        results_seen++;
        if (want.found) hits_seen++;
      end
    end
  end

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.opcode = OP_LOAD;
    item_ch.char_value = '0;
    item_ch.needle_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_NEEDLE_LENGTH;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    foreach (needle_mem[i]) needle_mem[i] = '0;
    foreach (slot_written[i]) slot_written[i] = 1'b0;
    clear_search();
    cur_len = '0;
    cur_exact = 1'b1;
    cur_whole = 1'b0;
    cur_offset = '0;
    burst_left = 0;
    words_sent = 0;
    results_seen = 0;
    hits_seen = 0;
    reg_writes = 0;
    err_count = 0;
    ready_mode = 0;
    ready_left = 0;
    ready_tick = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero needle length after reset never matches
    add_word(OP_TEXT, CH_UPPER_A, '0);
    add_end(1'b1, 1'b0, '0);
    // exact two-character needle at the character extremes, text after the match ignored
    add_reg(REG_NEEDLE_LENGTH, 31'd2);
    add_word(OP_LOAD, CH_UPPER_A, 6'd0);
    add_word(OP_LOAD, 16'hFFFF, 6'd1);
    add_word(OP_TEXT, 16'h0000, '0);
    add_word(OP_TEXT, CH_UPPER_A, '0);
    add_word(OP_TEXT, 16'hFFFF, '0);
    add_word(OP_TEXT, CH_UPPER_A, '0);
    add_end(1'b1, 1'b1, 31'd1);
    // text shorter than the needle
    add_word(OP_TEXT, CH_UPPER_A, '0);
    add_end(1'b1, 1'b0, '0);
    // folded whole-word search: first candidate dropped by its right side,
    // second one closed by end of text
    add_reg(REG_CASE_SENSITIVE, 31'd0);
    add_reg(REG_WHOLE_WORDS, 31'd1);
    add_word(OP_LOAD, CH_LOWER_A, 6'd0);
    add_word(OP_LOAD, CH_UNDERSCORE, 6'd1);
    add_word(OP_TEXT, 16'h0020, '0);
    add_word(OP_TEXT, CH_UPPER_A, '0);
    add_word(OP_TEXT, CH_UNDERSCORE, '0);
    add_word(OP_TEXT, CH_LOWER_A + 16'd1, '0);
    add_word(OP_TEXT, 16'h0020, '0);
    add_word(OP_TEXT, CH_LOWER_A, '0);
    add_word(OP_TEXT, CH_UNDERSCORE, '0);
    add_end(1'b0, 1'b0, '0);
    // unknown opcode, last needle slot, needle longer than the store, offset at the top
    add_word(OP_ILLEGAL, 16'hFFFF, 6'd63);
    add_word(OP_LOAD, 16'h1234, 6'd63);
    add_reg(REG_NEEDLE_LENGTH, 31'd127);
    add_reg(REG_START_OFFSET, POS_MAX);
    add_word(OP_TEXT, CH_UPPER_A, '0);
    add_end(1'b1, 1'b0, '0);

    foreach (script[i]) begin
      if (script[i].reg_row) begin
        write_reg(script[i].reg_sel, script[i].data);
      end else begin
        send_word(script[i].op, script[i].ch, script[i].idx, script[i].typed, script[i].want);
      end
    end

    run_phase(1'b1);
    while (words_sent < 1100) run_phase(1'b0);

    item_ch.valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d input words across %0d register writes", words_sent, reg_writes);
    $display("checked %0d search results, %0d of them matches", results_seen, hits_seen);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
